// ===== rtl/mwsm_pkg.sv =====
// Shared types, widths, register indexes and reset values of the mecanum wheel speed mixer.
package mwsm_pkg;

    // Field and register widths
    localparam int DATA_W      = 16;
    localparam int LIM_W       = 15;
    localparam int LEVER_W     = 16;
    localparam int RATIO_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_WHEELS  = 4;

    // Fixed point formats
    localparam int LEVER_FRAC_BITS     = 8;
    localparam int RATIO_FRAC_BITS_DEF = 16;

    // Saturation bounds of a wheel rpm magnitude
    localparam int MAG_POS_CAP = 32767;
    localparam int MAG_NEG_CAP = 32768;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SIDEWAYS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FORWARD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TURN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_LEVER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_LEVER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_SPEED  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RPM_LIM  = 3'd6;

    // Register reset values
    localparam logic [LIM_W-1:0]   RST_LIMIT_SIDEWAYS = 15'd3000;
    localparam logic [LIM_W-1:0]   RST_LIMIT_FORWARD  = 15'd3000;
    localparam logic [LIM_W-1:0]   RST_LIMIT_TURN     = 15'd300;
    localparam logic [LEVER_W-1:0] RST_FRONT_LEVER    = 16'd1024;
    localparam logic [LEVER_W-1:0] RST_REAR_LEVER     = 16'd1024;
    localparam logic [RATIO_W-1:0] RST_RPM_PER_SPEED  = 24'd1000;
    localparam logic [LIM_W-1:0]   RST_WHEEL_RPM_LIM  = 15'd8500;

    // Wheel lanes
    localparam int WHEEL_RF = 0;
    localparam int WHEEL_LF = 1;
    localparam int WHEEL_LR = 2;
    localparam int WHEEL_RR = 3;

    // Chassis velocity command
    typedef struct packed {
        logic signed [DATA_W-1:0] speed_sideways;
        logic signed [DATA_W-1:0] speed_forward;
        logic signed [DATA_W-1:0] turn_rate;
    } cmd_t;

    // Wheel rpm result
    typedef struct packed {
        logic signed [DATA_W-1:0] rpm_right_front;
        logic signed [DATA_W-1:0] rpm_left_front;
        logic signed [DATA_W-1:0] rpm_left_rear;
        logic signed [DATA_W-1:0] rpm_right_rear;
    } rpm_t;

endpackage

// ===== rtl/mecanum_wheel_speed_mixer.sv =====
// Mecanum wheel speed mixer: clamp, mix, rpm scaling and pipelined desaturation.
// Pipeline: 24 register stages; one item per cycle while the output is not stalled.
// Each of the four lanes has its own multipliers and a 15-stage restoring divider (one
// quotient bit per stage) for the limit/max scaling.
// A stalled result holds its stage; earlier stages keep filling empty slots behind it.
// Reset (aresetn low, synchronous) empties every stage and loads the default registers.
module mecanum_wheel_speed_mixer #(
    parameter int RATIO_FRAC_BITS = mwsm_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // command input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mwsm_pkg::cmd_t                        s_data,
    // rpm output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mwsm_pkg::rpm_t                        m_data
);

    localparam int NW         = mwsm_pkg::NUM_WHEELS;
    localparam int DW         = mwsm_pkg::DATA_W;
    localparam int LIM_W      = mwsm_pkg::LIM_W;
    localparam int RATIO_W    = mwsm_pkg::RATIO_W;
    localparam int SHIFT      = mwsm_pkg::LEVER_FRAC_BITS + RATIO_FRAC_BITS;
    localparam int SUM_W      = 33;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = MAG_W + RATIO_W;
    localparam int RPM_W      = 16;
    localparam int QUO_W      = LIM_W;
    localparam int NUM_W      = RPM_W + LIM_W;
    localparam int REM_W      = RPM_W;
    localparam int DIV_STAGES = QUO_W;

    // Stage map
    localparam int ST_CLAMP = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_ABS   = 3;
    localparam int ST_RATIO = 4;
    localparam int ST_SAT   = 5;
    localparam int ST_MAX   = 6;
    localparam int ST_SETUP = 7;
    localparam int ST_OUT   = ST_SETUP + DIV_STAGES + 1;
    localparam int NS       = ST_OUT + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LIM_W-1:0]                 lim_side_reg;
    logic [LIM_W-1:0]                 lim_fwd_reg;
    logic [LIM_W-1:0]                 lim_turn_reg;
    logic [mwsm_pkg::LEVER_W-1:0]     front_lever_reg;
    logic [mwsm_pkg::LEVER_W-1:0]     rear_lever_reg;
    logic [RATIO_W-1:0]               rpm_ratio_reg;
    logic [LIM_W-1:0]                 rpm_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_side_reg    <= mwsm_pkg::RST_LIMIT_SIDEWAYS;
            lim_fwd_reg     <= mwsm_pkg::RST_LIMIT_FORWARD;
            lim_turn_reg    <= mwsm_pkg::RST_LIMIT_TURN;
            front_lever_reg <= mwsm_pkg::RST_FRONT_LEVER;
            rear_lever_reg  <= mwsm_pkg::RST_REAR_LEVER;
            rpm_ratio_reg   <= mwsm_pkg::RST_RPM_PER_SPEED;
            rpm_lim_reg     <= mwsm_pkg::RST_WHEEL_RPM_LIM;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mwsm_pkg::REG_LIMIT_SIDEWAYS: lim_side_reg    <= cfg_wdata[LIM_W-1:0];
                mwsm_pkg::REG_LIMIT_FORWARD:  lim_fwd_reg     <= cfg_wdata[LIM_W-1:0];
                mwsm_pkg::REG_LIMIT_TURN:     lim_turn_reg    <= cfg_wdata[LIM_W-1:0];
                mwsm_pkg::REG_FRONT_LEVER:
                    front_lever_reg <= cfg_wdata[mwsm_pkg::LEVER_W-1:0];
                mwsm_pkg::REG_REAR_LEVER:
                    rear_lever_reg  <= cfg_wdata[mwsm_pkg::LEVER_W-1:0];
                mwsm_pkg::REG_RPM_PER_SPEED:  rpm_ratio_reg   <= cfg_wdata[RATIO_W-1:0];
                mwsm_pkg::REG_WHEEL_RPM_LIM:  rpm_lim_reg     <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage advance
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // a stage loads when it is empty or its item moves on
    assign en[NS-1] = !vld_reg[NS-1] || m_ready;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 0: symmetric clamp per axis
    // ------------------------------------------------------------------
    function automatic logic signed [DW-1:0] clamp_sym(
        input logic signed [DW-1:0] v,
        input logic [LIM_W-1:0]     lim
    );
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        hi = $signed({1'b0, lim});
        lo = -hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    logic signed [DW-1:0] x0_reg;
    logic signed [DW-1:0] y0_reg;
    logic signed [DW-1:0] w0_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_CLAMP]) begin
            x0_reg <= clamp_sym(s_data.speed_sideways, lim_side_reg);
            y0_reg <= clamp_sym(s_data.speed_forward, lim_fwd_reg);
            w0_reg <= clamp_sym(s_data.turn_rate, lim_turn_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: turn rate times lever ratios (Q8.8)
    // ------------------------------------------------------------------
    logic signed [DW-1:0]    x1_reg;
    logic signed [DW-1:0]    y1_reg;
    logic signed [SUM_W-1:0] tf1_reg;
    logic signed [SUM_W-1:0] tr1_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            tf1_reg <= SUM_W'(w0_reg) * SUM_W'($signed({1'b0, front_lever_reg}));
            tr1_reg <= SUM_W'(w0_reg) * SUM_W'($signed({1'b0, rear_lever_reg}));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: wheel mixing with 8 fraction bits
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum2_reg [NW];
    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] ys;

    assign xs = SUM_W'(x1_reg) <<< mwsm_pkg::LEVER_FRAC_BITS;
    assign ys = SUM_W'(y1_reg) <<< mwsm_pkg::LEVER_FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            sum2_reg[mwsm_pkg::WHEEL_RF] <= xs - ys + tf1_reg;
            sum2_reg[mwsm_pkg::WHEEL_LF] <= xs + ys + tf1_reg;
            sum2_reg[mwsm_pkg::WHEEL_LR] <= ys - xs + tr1_reg;
            sum2_reg[mwsm_pkg::WHEEL_RR] <= tr1_reg - xs - ys;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sign and magnitude
    // ------------------------------------------------------------------
    logic [NW-1:0]    neg3_reg;
    logic [MAG_W-1:0] mag3_reg [NW];

    always_ff @(posedge aclk) begin
        if (en[ST_ABS]) begin
            for (int i = 0; i < NW; i++) begin
                neg3_reg[i] <= sum2_reg[i][SUM_W-1];
                mag3_reg[i] <= sum2_reg[i][SUM_W-1] ? MAG_W'(-sum2_reg[i])
                                                     : MAG_W'(sum2_reg[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitude times rpm ratio
    // ------------------------------------------------------------------
    logic [NW-1:0]     neg4_reg;
    logic [PROD_W-1:0] prod4_reg [NW];

    always_ff @(posedge aclk) begin
        if (en[ST_RATIO]) begin
            neg4_reg <= neg3_reg;
            for (int i = 0; i < NW; i++) begin
                prod4_reg[i] <= PROD_W'(mag3_reg[i]) * PROD_W'(rpm_ratio_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: drop fraction bits, saturate to signed 16-bit range
    // ------------------------------------------------------------------
    logic [NW-1:0]    neg5_reg;
    logic [RPM_W-1:0] mag5_reg [NW];
    logic [PROD_W-1:0] shifted [NW];
    logic [PROD_W-1:0] cap     [NW];

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            shifted[i] = prod4_reg[i] >> SHIFT;
            cap[i]     = neg4_reg[i] ? PROD_W'(mwsm_pkg::MAG_NEG_CAP)
                                     : PROD_W'(mwsm_pkg::MAG_POS_CAP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SAT]) begin
            neg5_reg <= neg4_reg;
            for (int i = 0; i < NW; i++) begin
                mag5_reg[i] <= (shifted[i] > cap[i]) ? cap[i][RPM_W-1:0]
                                                     : shifted[i][RPM_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: largest magnitude and scaling numerators mag*limit
    // ------------------------------------------------------------------
    logic [NW-1:0]    neg6_reg;
    logic [RPM_W-1:0] mag6_reg [NW];
    logic [RPM_W-1:0] max6_reg;
    logic [NUM_W-1:0] num6_reg [NW];
    logic [RPM_W-1:0] max01;
    logic [RPM_W-1:0] max23;

    assign max01 = (mag5_reg[0] > mag5_reg[1]) ? mag5_reg[0] : mag5_reg[1];
    assign max23 = (mag5_reg[2] > mag5_reg[3]) ? mag5_reg[2] : mag5_reg[3];

    always_ff @(posedge aclk) begin
        if (en[ST_MAX]) begin
            neg6_reg <= neg5_reg;
            max6_reg <= (max01 > max23) ? max01 : max23;
            for (int i = 0; i < NW; i++) begin
                mag6_reg[i] <= mag5_reg[i];
                num6_reg[i] <= NUM_W'(mag5_reg[i]) * NUM_W'(rpm_lim_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: desaturation decision and divider setup
    // Quotient fits in 15 bits, so the top bits of the numerator seed the
    // remainder, which then stays below max.
    // ------------------------------------------------------------------
    logic [NW-1:0]    div_neg_reg   [DIV_STAGES+1];
    logic [RPM_W-1:0] div_mag_reg   [DIV_STAGES+1][NW];
    logic [RPM_W-1:0] div_max_reg   [DIV_STAGES+1];
    logic             div_desat_reg [DIV_STAGES+1];
    logic [REM_W-1:0] div_rem_reg   [DIV_STAGES+1][NW];
    logic [QUO_W-1:0] div_low_reg   [DIV_STAGES+1][NW];
    logic [QUO_W-1:0] div_quo_reg   [DIV_STAGES+1][NW];

    always_ff @(posedge aclk) begin
        if (en[ST_SETUP]) begin
            div_neg_reg[0]   <= neg6_reg;
            div_max_reg[0]   <= max6_reg;
            div_desat_reg[0] <= max6_reg > {1'b0, rpm_lim_reg};
            for (int i = 0; i < NW; i++) begin
                div_mag_reg[0][i] <= mag6_reg[i];
                div_rem_reg[0][i] <= num6_reg[i][NUM_W-1:QUO_W];
                div_low_reg[0][i] <= num6_reg[i][QUO_W-1:0];
                div_quo_reg[0][i] <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 8..22: restoring division, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar d = 1; d <= DIV_STAGES; d++) begin : g_div
        logic [REM_W:0]   trial [NW];
        logic [REM_W:0]   diff  [NW];
        logic [REM_W-1:0] rem_nx [NW];
        logic [NW-1:0]    qbit;

        always_comb begin
            for (int i = 0; i < NW; i++) begin
                trial[i] = {div_rem_reg[d-1][i], div_low_reg[d-1][i][QUO_W-1]};
                diff[i]  = trial[i] - {1'b0, div_max_reg[d-1]};
                qbit[i]  = trial[i] >= {1'b0, div_max_reg[d-1]};
                rem_nx[i] = qbit[i] ? diff[i][REM_W-1:0] : trial[i][REM_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[ST_SETUP + d]) begin
                div_neg_reg[d]   <= div_neg_reg[d-1];
                div_max_reg[d]   <= div_max_reg[d-1];
                div_desat_reg[d] <= div_desat_reg[d-1];
                for (int i = 0; i < NW; i++) begin
                    div_mag_reg[d][i] <= div_mag_reg[d-1][i];
                    div_rem_reg[d][i] <= rem_nx[i];
                    div_low_reg[d][i] <= {div_low_reg[d-1][i][QUO_W-2:0], 1'b0};
                    div_quo_reg[d][i] <= {div_quo_reg[d-1][i][QUO_W-2:0], qbit[i]};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 23: pick scaled or plain magnitude, restore sign
    // ------------------------------------------------------------------
    logic [RPM_W-1:0] sel_mag [NW];
    logic [RPM_W-1:0] sel_rpm [NW];
    mwsm_pkg::rpm_t   out_reg;

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            sel_mag[i] = div_desat_reg[DIV_STAGES] ? RPM_W'(div_quo_reg[DIV_STAGES][i])
                                                   : div_mag_reg[DIV_STAGES][i];
            sel_rpm[i] = div_neg_reg[DIV_STAGES][i] ? RPM_W'(0) - sel_mag[i] : sel_mag[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_reg.rpm_right_front <= $signed(sel_rpm[mwsm_pkg::WHEEL_RF]);
            out_reg.rpm_left_front  <= $signed(sel_rpm[mwsm_pkg::WHEEL_LF]);
            out_reg.rpm_left_rear   <= $signed(sel_rpm[mwsm_pkg::WHEEL_LR]);
            out_reg.rpm_right_rear  <= $signed(sel_rpm[mwsm_pkg::WHEEL_RR]);
        end
    end

    assign m_data = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a positive saturated magnitude never reaches 32768
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_SAT] |->
            (neg5_reg[0] || mag5_reg[0] <= RPM_W'(mwsm_pkg::MAG_POS_CAP)) &&
            (neg5_reg[1] || mag5_reg[1] <= RPM_W'(mwsm_pkg::MAG_POS_CAP)) &&
            (neg5_reg[2] || mag5_reg[2] <= RPM_W'(mwsm_pkg::MAG_POS_CAP)) &&
            (neg5_reg[3] || mag5_reg[3] <= RPM_W'(mwsm_pkg::MAG_POS_CAP)))
        else $error("positive wheel rpm above signed 16-bit range");

    // the max tree bounds every lane
    a_max_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_MAX] |->
            (mag6_reg[0] <= max6_reg) && (mag6_reg[1] <= max6_reg) &&
            (mag6_reg[2] <= max6_reg) && (mag6_reg[3] <= max6_reg))
        else $error("max tree smaller than a wheel magnitude");

    // divider remainder stays below the divisor through the last step
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_OUT-1] && div_desat_reg[DIV_STAGES]) |->
            (div_rem_reg[DIV_STAGES][0] < div_max_reg[DIV_STAGES]) &&
            (div_rem_reg[DIV_STAGES][1] < div_max_reg[DIV_STAGES]) &&
            (div_rem_reg[DIV_STAGES][2] < div_max_reg[DIV_STAGES]) &&
            (div_rem_reg[DIV_STAGES][3] < div_max_reg[DIV_STAGES]))
        else $error("divider remainder not below max");

endmodule
